/* rtl/opi_pkg.sv */
package opi_pkg;

  // Heading in Q2.13 radians
  localparam int PI_Q13      = 25736;
  localparam int TWO_PI_Q13  = 51472;
  // Offset (a multiple of 2*pi) that keeps the heading sum non-negative
  localparam int WRAP_OFFSET = TWO_PI_Q13 * 8192;

  // CORDIC angles and gain in Q2.30
  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [33:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
  localparam int CORDIC_W = 34;

  // Heading wrap: floor(u / 2pi) as (u * MOD_RECIP) >> MOD_SHIFT, exact for u < 2^30
  localparam int MOD_SHIFT = 46;
  localparam logic [63:0] MOD_RECIP =
      ((64'd1 << MOD_SHIFT) + 64'(TWO_PI_Q13) - 64'd1) / 64'(TWO_PI_Q13);

  // Turn-rate divider widths
  localparam int DIV_NUM_W = 56;
  localparam int DIV_DEN_W = 24;
  localparam int DIV_Q_W   = 32;

  typedef enum logic [1:0] {
    CFG_WHEEL_SIZE = 2'd0,
    CFG_WHEEL_BASE = 2'd1,
    CFG_REVERSE    = 2'd2
  } cfg_index_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_TR,
    ST_DIST,
    ST_ROT1,
    ST_SPD,
    ST_ROT2,
    ST_ROTS,
    ST_WRAP,
    ST_MODQ,
    ST_QSTORE,
    ST_MODR,
    ST_MODS,
    ST_WAITC,
    ST_PX,
    ST_PY,
    ST_WAITD,
    ST_FIN
  } opi_state_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic               ovf;
    logic [DIV_Q_W-1:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic               start;
    logic signed [15:0] angle;
  } cordic_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] cos_v;
    logic signed [31:0] sin_v;
  } cordic_rsp_t;

  // Truncated atan(2^-i) in Q2.30
  function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
    logic signed [33:0] a;
    case (i)
      5'd0:    a = 34'sh03243F6A8;
      5'd1:    a = 34'sh01DAC6705;
      5'd2:    a = 34'sh00FADBAFC;
      5'd3:    a = 34'sh007F56EA6;
      5'd4:    a = 34'sh003FEAB76;
      5'd5:    a = 34'sh001FFD55B;
      5'd6:    a = 34'sh000FFFAAA;
      5'd7:    a = 34'sh0007FFF55;
      5'd8:    a = 34'sh0003FFFEA;
      5'd9:    a = 34'sh0001FFFFD;
      5'd10:   a = 34'sh0000FFFFF;
      5'd11:   a = 34'sh00007FFFF;
      5'd12:   a = 34'sh00003FFFF;
      5'd13:   a = 34'sh00001FFFF;
      5'd14:   a = 34'sh00000FFFF;
      5'd15:   a = 34'sh000007FFF;
      5'd16:   a = 34'sh000003FFF;
      5'd17:   a = 34'sh000001FFF;
      5'd18:   a = 34'sh000000FFF;
      5'd19:   a = 34'sh0000007FF;
      5'd20:   a = 34'sh0000003FF;
      5'd21:   a = 34'sh0000001FF;
      5'd22:   a = 34'sh0000000FF;
      5'd23:   a = 34'sh00000007F;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

/* rtl/opi_div.sv */
// Restoring divider: one quotient bit per cycle.
// Quotients that do not fit DIV_Q_W bits are flagged as overflow up front.
module opi_div (
  input  logic              clk,
  input  logic              rst,
  input  opi_pkg::div_req_t req,
  output opi_pkg::div_rsp_t rsp
);

  localparam int NW = opi_pkg::DIV_NUM_W;
  localparam int DW = opi_pkg::DIV_DEN_W;
  localparam int QW = opi_pkg::DIV_Q_W;
  localparam int CW = $clog2(QW);

  logic [DW-1:0] rem;
  logic [DW-1:0] den;
  logic [QW-1:0] low;
  logic [QW-1:0] quot;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;
  logic          ovf;
  logic          ovf_start;
  logic [DW:0]   trial;
  logic          fits;

  // High part of the numerator must stay below the divisor
  assign ovf_start = (req.num[NW-1:QW] >= req.den);

  // Trial subtraction
  assign trial = {rem, low[QW-1]};
  assign fits  = (trial >= {1'b0, den});

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CW'(QW - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      den  <= req.den;
      ovf  <= ovf_start;
      rem  <= ovf_start ? '0 : req.num[NW-1:QW];
      low  <= req.num[QW-1:0];
      quot <= '0;
    end else if (busy) begin
      rem  <= fits ? DW'(trial - {1'b0, den}) : trial[DW-1:0];
      low  <= {low[QW-2:0], 1'b0};
      quot <= {quot[QW-2:0], fits};
    end
  end

  assign rsp.done = done;
  assign rsp.ovf  = ovf;
  assign rsp.quot = quot;

endmodule

/* rtl/opi_cordic.sv */
// Rotation-mode CORDIC, one micro-rotation per cycle.
// Angles beyond +-pi/2 are folded by pi and the results negated.
module opi_cordic #(
  parameter int STEPS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  opi_pkg::cordic_req_t req,
  output opi_pkg::cordic_rsp_t rsp
);

  localparam int W  = opi_pkg::CORDIC_W;
  localparam int CW = $clog2(STEPS + 1);

  logic signed [W-1:0] x;
  logic signed [W-1:0] y;
  logic signed [W-1:0] z;
  logic signed [W-1:0] z0;
  logic signed [W-1:0] shx;
  logic signed [W-1:0] shy;
  logic signed [W-1:0] ang;
  logic signed [W-1:0] cos_full;
  logic signed [W-1:0] sin_full;
  logic                neg;
  logic [CW-1:0]       cnt;
  logic                busy;
  logic                done;

  // Heading Q2.13 to Q2.30
  assign z0  = W'(req.angle) <<< 17;
  assign shx = x >>> cnt;
  assign shy = y >>> cnt;
  assign ang = opi_pkg::atan_q30(5'(cnt));

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CW'(STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Micro-rotations
  always_ff @(posedge clk) begin
    if (req.start) begin
      x <= opi_pkg::GAIN_Q30;
      y <= '0;
      if (z0 > opi_pkg::HALF_PI_Q30) begin
        z   <= z0 - opi_pkg::PI_Q30;
        neg <= 1'b1;
      end else if (z0 < -opi_pkg::HALF_PI_Q30) begin
        z   <= z0 + opi_pkg::PI_Q30;
        neg <= 1'b1;
      end else begin
        z   <= z0;
        neg <= 1'b0;
      end
    end else if (busy) begin
      if (z >= 0) begin
        x <= x - shy;
        y <= y + shx;
        z <= z - ang;
      end else begin
        x <= x + shy;
        y <= y - shx;
        z <= z + ang;
      end
    end
  end

  // Results stay within +-2^30, so 32 bits hold them
  assign cos_full  = neg ? -x : x;
  assign sin_full  = neg ? -y : y;
  assign rsp.done  = done;
  assign rsp.cos_v = cos_full[31:0];
  assign rsp.sin_v = sin_full[31:0];

endmodule

/* rtl/odometry_pose_integrator_unit.sv */
// Dead-reckoning pose integrator for a differential-drive base.
// Input channel: item_valid / item_stall with op, step_distance, step_turn,
//   speed_in and turn_rate_in. An item is taken when item_valid is high and
//   item_stall is low; item_stall is high while an item is being worked on.
// Result channel: result_valid / result_stall with pos_x, pos_y, heading,
//   speed_out and turn_rate_out, one result per item, from an output register.
// Config channel: cfg_valid / cfg_ready (always ready), cfg_index selects
//   wheel size (0), wheelbase (1) or reverse flag (2); other indexes are ignored.
// Sequence: an integrate item's result waits for the 32-step restoring divider
//   for the turn rate, which starts in ST_ROT1 after ST_TR and ST_DIST and runs
//   alongside the CORDIC and the single shared 32x33 multiplier sequence. With no
//   result stall the next item is taken once the unit is back in ST_IDLE.
//   A clear item goes from ST_IDLE straight to ST_FIN to commit its result.
//   One item is in work at a time.
// Reset clears the pose and speeds and sets both factors to 1.0, reverse off.
// A stalled result holds in the output register; the next item is accepted
//   and worked on meanwhile, and its result waits until the register frees.
module odometry_pose_integrator_unit #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  // Input items
  input  logic               item_valid,
  output logic               item_stall,
  input  logic               op,
  input  logic signed [31:0] step_distance,
  input  logic signed [31:0] step_turn,
  input  logic signed [31:0] speed_in,
  input  logic signed [31:0] turn_rate_in,
  // Results
  output logic               result_valid,
  input  logic               result_stall,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [15:0] heading,
  output logic signed [31:0] speed_out,
  output logic signed [31:0] turn_rate_out,
  // Configuration
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data
);

  localparam int MS = opi_pkg::MOD_SHIFT;

  // Configuration registers
  logic [23:0] wheel_size_scale;
  logic [23:0] wheel_base_scale;
  logic        reverse_direction;

  // Pose state
  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic signed [15:0] pose_heading;
  logic signed [31:0] last_speed;
  logic signed [31:0] last_turn_rate;

  // Captured item
  logic signed [31:0] dist_in;
  logic signed [31:0] turn_in;
  logic signed [31:0] spd_in;
  logic signed [31:0] trate_in;

  // Work registers
  logic signed [31:0] dist_r;
  logic signed [31:0] rot1_r;
  logic signed [31:0] rot_r;
  logic signed [31:0] spd_r;
  logic signed [31:0] trate_r;
  logic signed [31:0] x_new;
  logic signed [31:0] y_new;
  logic signed [15:0] h_new;
  logic [55:0]        p_mag;
  logic               p_neg;
  logic [29:0]        u_r;
  logic [14:0]        q_r;

  // Shared multiplier
  logic signed [31:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [64:0] prod;

  opi_pkg::opi_state_t  state, state_next;
  opi_pkg::div_req_t    dreq;
  opi_pkg::div_rsp_t    drsp;
  opi_pkg::cordic_req_t creq;
  opi_pkg::cordic_rsp_t crsp;

  logic               accept;
  logic               commit;
  logic [23:0]        den;
  logic signed [32:0] rot_sh;
  logic signed [32:0] u_sum;
  logic [29:0]        rem30;
  logic signed [16:0] h_wrap;
  logic signed [31:0] scaled;
  logic signed [31:0] trate_calc;

  function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
    logic signed [31:0] r;
    if (v > 65'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -65'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Q8.16 product back to Q16.16, round half up, saturate
  function automatic logic signed [31:0] scale16(input logic signed [64:0] v);
    logic signed [64:0] t;
    t = (v + 65'sd32768) >>> 16;
    return sat32(t);
  endfunction

  function automatic logic signed [31:0] neg_sat(input logic signed [31:0] v);
    logic signed [31:0] r;
    r = (v == 32'sh80000000) ? 32'sh7fffffff : -v;
    return r;
  endfunction

  // Position plus Q2.30 product shifted back with rounding, saturated
  function automatic logic signed [31:0] pos_add(input logic signed [31:0] p,
                                                 input logic signed [64:0] m);
    logic signed [64:0] t;
    t = ((m + 65'sd536870912) >>> 30) + 65'(p);
    return sat32(t);
  endfunction

  assign accept    = item_valid && !item_stall;
  assign commit    = (state == opi_pkg::ST_FIN) && (!result_valid || !result_stall);
  assign cfg_ready = 1'b1;
  assign den       = (wheel_base_scale == '0) ? 24'd1 : wheel_base_scale;
  assign scaled    = scale16(prod);

  // Heading wrap terms
  assign rot_sh = (33'(rot_r) + 33'sd4) >>> 3;
  assign u_sum  = rot_sh + 33'(pose_heading) + 33'(opi_pkg::PI_Q13)
                + 33'(opi_pkg::WRAP_OFFSET);
  assign rem30  = u_r - prod[29:0];
  assign h_wrap = $signed({1'b0, rem30[15:0]}) - 17'(opi_pkg::PI_Q13);

  // Turn-rate sign and saturation
  always_comb begin
    if (p_neg) begin
      trate_calc = (drsp.ovf || drsp.quot[31]) ? 32'sh80000000 : -$signed(drsp.quot);
    end else begin
      trate_calc = (drsp.ovf || drsp.quot[31]) ? 32'sh7fffffff : $signed(drsp.quot);
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      wheel_size_scale  <= 24'd65536;
      wheel_base_scale  <= 24'd65536;
      reverse_direction <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        opi_pkg::CFG_WHEEL_SIZE: wheel_size_scale  <= cfg_data;
        opi_pkg::CFG_WHEEL_BASE: wheel_base_scale  <= cfg_data;
        opi_pkg::CFG_REVERSE:    reverse_direction <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= opi_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer: next state, multiplier operands, unit starts
  always_comb begin
    state_next  = state;
    item_stall  = 1'b1;
    mul_a       = dist_r;
    mul_b       = 33'(crsp.cos_v);
    dreq.start  = 1'b0;
    dreq.num    = 56'(p_mag) + 56'(den >> 1);
    dreq.den    = den;
    creq.start  = 1'b0;
    creq.angle  = pose_heading;
    case (state)
      opi_pkg::ST_IDLE: begin
        item_stall = 1'b0;
        if (item_valid) begin
          creq.start = !op;
          state_next = op ? opi_pkg::ST_FIN : opi_pkg::ST_TR;
        end
      end
      opi_pkg::ST_TR: begin
        mul_a      = trate_in;
        mul_b      = $signed({9'b0, wheel_size_scale});
        state_next = opi_pkg::ST_DIST;
      end
      opi_pkg::ST_DIST: begin
        mul_a      = dist_in;
        mul_b      = $signed({9'b0, wheel_size_scale});
        state_next = opi_pkg::ST_ROT1;
      end
      opi_pkg::ST_ROT1: begin
        dreq.start = 1'b1;
        mul_a      = turn_in;
        mul_b      = $signed({9'b0, wheel_size_scale});
        state_next = opi_pkg::ST_SPD;
      end
      opi_pkg::ST_SPD: begin
        mul_a      = spd_in;
        mul_b      = $signed({9'b0, wheel_size_scale});
        state_next = opi_pkg::ST_ROT2;
      end
      opi_pkg::ST_ROT2: begin
        mul_a      = rot1_r;
        mul_b      = $signed({9'b0, wheel_base_scale});
        state_next = opi_pkg::ST_ROTS;
      end
      opi_pkg::ST_ROTS:   state_next = opi_pkg::ST_WRAP;
      opi_pkg::ST_WRAP:   state_next = opi_pkg::ST_MODQ;
      opi_pkg::ST_MODQ: begin
        mul_a      = $signed({2'b0, u_r});
        mul_b      = $signed(opi_pkg::MOD_RECIP[32:0]);
        state_next = opi_pkg::ST_QSTORE;
      end
      opi_pkg::ST_QSTORE: state_next = opi_pkg::ST_MODR;
      opi_pkg::ST_MODR: begin
        mul_a      = $signed({17'b0, q_r});
        mul_b      = 33'(opi_pkg::TWO_PI_Q13);
        state_next = opi_pkg::ST_MODS;
      end
      opi_pkg::ST_MODS:   state_next = opi_pkg::ST_WAITC;
      opi_pkg::ST_WAITC: begin
        if (crsp.done) begin
          state_next = opi_pkg::ST_PX;
        end
      end
      opi_pkg::ST_PX: begin
        mul_b      = 33'(crsp.sin_v);
        state_next = opi_pkg::ST_PY;
      end
      opi_pkg::ST_PY:     state_next = opi_pkg::ST_WAITD;
      opi_pkg::ST_WAITD: begin
        if (drsp.done) begin
          state_next = opi_pkg::ST_FIN;
        end
      end
      opi_pkg::ST_FIN: begin
        if (commit) begin
          state_next = opi_pkg::ST_IDLE;
        end
      end
      default: state_next = opi_pkg::ST_IDLE;
    endcase
  end

  // Multiplier output register
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Work datapath
  always_ff @(posedge clk) begin
    case (state)
      opi_pkg::ST_IDLE: begin
        dist_in  <= step_distance;
        turn_in  <= step_turn;
        spd_in   <= speed_in;
        trate_in <= turn_rate_in;
        if (accept && op) begin
          x_new   <= '0;
          y_new   <= '0;
          h_new   <= '0;
          spd_r   <= last_speed;
          trate_r <= last_turn_rate;
        end
      end
      opi_pkg::ST_DIST: begin
        p_neg <= prod[64];
        p_mag <= prod[64] ? 56'(-prod) : prod[55:0];
      end
      opi_pkg::ST_ROT1:   dist_r <= reverse_direction ? neg_sat(scaled) : scaled;
      opi_pkg::ST_SPD:    rot1_r <= scaled;
      opi_pkg::ST_ROT2:   spd_r  <= reverse_direction ? neg_sat(scaled) : scaled;
      opi_pkg::ST_ROTS:   rot_r  <= scaled;
      opi_pkg::ST_WRAP:   u_r    <= u_sum[29:0];
      opi_pkg::ST_QSTORE: q_r    <= prod[MS +: 15];
      opi_pkg::ST_MODS:   h_new  <= h_wrap[15:0];
      opi_pkg::ST_PX:     x_new  <= pos_add(pose_x, prod);
      opi_pkg::ST_PY:     y_new  <= pos_add(pose_y, prod);
      opi_pkg::ST_WAITD: begin
        if (drsp.done) begin
          trate_r <= trate_calc;
        end
      end
      default: ;
    endcase
  end

  // Pose state commit
  always_ff @(posedge clk) begin
    if (rst) begin
      pose_x         <= '0;
      pose_y         <= '0;
      pose_heading   <= '0;
      last_speed     <= '0;
      last_turn_rate <= '0;
    end else if (commit) begin
      pose_x         <= x_new;
      pose_y         <= y_new;
      pose_heading   <= h_new;
      last_speed     <= spd_r;
      last_turn_rate <= trate_r;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (commit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      pos_x         <= x_new;
      pos_y         <= y_new;
      heading       <= h_new;
      speed_out     <= spd_r;
      turn_rate_out <= trate_r;
    end
  end

  opi_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  opi_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk (clk),
    .rst (rst),
    .req (creq),
    .rsp (crsp)
  );

endmodule
